@@ rtl/core/x86ild_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package x86ild_pkg;
  localparam int unsigned MaxLength = 15;

  typedef enum logic [10:0] {
    PH_START     = 11'b00000000001,
    PH_AFTER_REX = 11'b00000000010,
    PH_VEX3_B1   = 11'b00000000100,
    PH_VEX3_B2   = 11'b00000001000,
    PH_VEX2_B1   = 11'b00000010000,
    PH_VEX_OP    = 11'b00000100000,
    PH_ESC       = 11'b00001000000,
    PH_ESC3      = 11'b00010000000,
    PH_MODRM     = 11'b00100000000,
    PH_SIB       = 11'b01000000000,
    PH_DISP      = 11'b10000000000
  } phase_t;

  localparam logic [7:0] OpSize = 8'h66;
  localparam logic [7:0] AdSize = 8'h67;
  localparam logic [7:0] RepNe  = 8'hF2;
  localparam logic [7:0] Rep    = 8'hF3;
  localparam logic [7:0] SegEs  = 8'h26;
  localparam logic [7:0] SegCs  = 8'h2E;
  localparam logic [7:0] SegSs  = 8'h36;
  localparam logic [7:0] SegDs  = 8'h3E;
  localparam logic [7:0] SegFs  = 8'h64;
  localparam logic [7:0] SegGs  = 8'h65;
  localparam logic [7:0] Vex3   = 8'hC4;
  localparam logic [7:0] Vex2   = 8'hC5;
  localparam logic [7:0] Esc    = 8'h0F;
  localparam logic [7:0] Esc38  = 8'h38;
  localparam logic [7:0] Esc3A  = 8'h3A;

  localparam int unsigned FlModrm = 0;
  localparam int unsigned FlSib   = 1;
  localparam int unsigned FlDisp  = 2;
  localparam int unsigned FlSimd  = 3;
  localparam int unsigned FlRex   = 4;
  localparam int unsigned FlVex   = 5;

  typedef struct packed {
    logic [3:0]  length;
    logic [1:0]  opc_map;
    logic [7:0]  opcode_value;
    logic [2:0]  prefix_flags;
    logic [3:0]  rex_bits;
    logic [5:0]  flags;
    logic [7:0]  modrm_val;
    logic [7:0]  sib_val;
    logic [31:0] displacement;
  } ild_rec_t;

  typedef struct packed {
    logic [3:0]  length;
    logic [1:0]  opc_map;
    logic [7:0]  opcode_value;
    logic [2:0]  prefix_flags;
    logic [3:0]  rex_bits;
    logic [5:0]  flags;
    logic [7:0]  modrm_val;
    logic [7:0]  sib_val;
    logic signed [31:0] displacement;
    logic [1:0]  operand_size_code;
    logic [3:0]  reg_index;
    logic [3:0]  rm_index;
  } ild_res_t;

  function automatic logic [15:0] map0_row(input logic [3:0] r);
    logic [15:0] v;
    unique case (r)
      4'h0, 4'h1, 4'h2, 4'h3: v = 16'h0F0F;
      4'h6: v = 16'h0A0C;
      4'h8: v = 16'hFFFF;
      4'hC: v = 16'h00F3;
      4'hD: v = 16'hFF0F;
      4'hF: v = 16'hC0C0;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic is_legacy(input logic [7:0] b);
    return b == OpSize || b == AdSize || b == RepNe || b == Rep ||
           b == SegEs || b == SegCs || b == SegSs || b == SegDs ||
           b == SegFs || b == SegGs;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/x86ild_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface x86ild_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       restart;
  modport source (output valid, code_byte, restart, input ready);
  modport sink (input valid, code_byte, restart, output ready);
endinterface

interface x86ild_out_if;
  import x86ild_pkg::*;
  logic     valid;
  logic     ready;
  ild_res_t res;
  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface
`default_nettype wire

@@ rtl/core/x86ild_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module x86ild_front
  import x86ild_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MaxLength
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic [7:0] code_byte,
  input  wire logic     restart,
  output logic          in_ready,
  output logic          rec_valid,
  output ild_rec_t      rec,
  input  wire logic     rec_ready
);
  phase_t      phase, phase_next;
  logic [3:0]  cnt, cnt_next;
  logic [2:0]  pfx, pfx_next;
  logic [3:0]  rex, rex_next;
  logic [5:0]  kind, kind_next;
  logic [1:0]  map, map_next;
  logic [7:0]  opc, opc_next, modrm, modrm_next, sib, sib_next;
  logic [31:0] disp, disp_next;
  logic [2:0]  rem, rem_next;
  logic        done;
  logic        acc;

  // opcode classification
  logic [1:0] op_map;
  logic [7:0] op_b;
  logic       need, simd;
  logic [2:0] dsz;
  logic       dok;

  assign in_ready = !rec_valid || rec_ready;
  assign acc = in_valid && in_ready;

  always_comb begin
    logic [15:0] row0;
    need = 1'b0;
    simd = 1'b0;
    row0 = map0_row(op_b[7:4]);
    if (op_map == 2'd1) begin
      need = op_b < 8'h06 || (op_b >= 8'h10 && op_b <= 8'h73) ||
             (op_b >= 8'h7C && op_b <= 8'h7F) || (op_b >= 8'h90 && op_b <= 8'h9F) ||
             op_b >= 8'hA3;
      simd = (op_b >= 8'h10 && op_b <= 8'h7F) ||
             (op_b >= 8'h90 && op_b != 8'hA0 && op_b != 8'hA1 && op_b != 8'hA2 &&
              op_b != 8'hA8 && op_b != 8'hA9 && op_b != 8'hB0 && op_b != 8'hB1);
    end else if (op_map != 2'd0) begin
      need = 1'b1;
      simd = 1'b1;
    end else begin
      need = row0[op_b[3:0]];
    end
  end

  always_comb begin
    logic [3:0] c0;
    logic [1:0] md;
    logic       b5;
    logic [4:0] sum;
    c0 = restart ? 4'd0 : cnt;
    phase_next = restart ? PH_START : phase;
    pfx_next = restart ? 3'd0 : pfx;
    rex_next = restart ? 4'd0 : rex;
    kind_next = restart ? 6'd0 : kind;
    map_next = restart ? 2'd0 : map;
    opc_next = restart ? 8'd0 : opc;
    modrm_next = restart ? 8'd0 : modrm;
    sib_next = restart ? 8'd0 : sib;
    disp_next = restart ? 32'd0 : disp;
    rem_next = restart ? 3'd0 : rem;
    cnt_next = c0 + 4'd1;
    done = 1'b0;
    op_map = 2'd0;
    op_b = code_byte;
    md = (phase_next == PH_SIB) ? modrm_next[7:6] : code_byte[7:6];
    b5 = code_byte[2:0] == 3'd5;
    unique case (md)
      2'd0: dsz = b5 ? 3'd4 : 3'd0;
      2'd1: dsz = 3'd1;
      2'd2: dsz = 3'd4;
      default: dsz = 3'd0;
    endcase
    sum = {1'b0, cnt_next} + {2'b0, dsz};
    dok = dsz != 3'd0 && sum <= 5'(MAX_LENGTH);
    unique case (phase_next)
      PH_START, PH_AFTER_REX: begin
        op_map = 2'd0;
        if (phase_next == PH_START && is_legacy(code_byte)) begin
          if (code_byte == OpSize) pfx_next[0] = 1'b1;
          if (code_byte == RepNe) pfx_next[1] = 1'b1;
          if (code_byte == Rep) pfx_next[2] = 1'b1;
        end else if (phase_next == PH_START && code_byte[7:4] == 4'h4) begin
          rex_next = code_byte[3:0];
          kind_next[FlRex] = 1'b1;
          phase_next = PH_AFTER_REX;
        end else if (code_byte == Vex3) begin
          kind_next[FlVex] = 1'b1;
          kind_next[FlRex] = 1'b1;
          phase_next = PH_VEX3_B1;
        end else if (code_byte == Vex2) begin
          kind_next[FlVex] = 1'b1;
          kind_next[FlRex] = 1'b1;
          phase_next = PH_VEX2_B1;
        end else if (code_byte == Esc) begin
          phase_next = PH_ESC;
        end else begin
          map_next = 2'd0;
          opc_next = code_byte;
          if (need) phase_next = PH_MODRM;
          else done = 1'b1;
        end
      end
      PH_VEX3_B1: begin
        rex_next = {1'b0, ~code_byte[7:5]};
        map_next = (code_byte[4:0] >= 5'd1 && code_byte[4:0] <= 5'd3) ?
                   code_byte[1:0] : 2'd0;
        phase_next = PH_VEX3_B2;
      end
      PH_VEX3_B2: begin
        rex_next[3] = code_byte[7];
        if (code_byte[1:0] == 2'd1) pfx_next[0] = 1'b1;
        if (code_byte[1:0] == 2'd2) pfx_next[1] = 1'b1;
        if (code_byte[1:0] == 2'd3) pfx_next[2] = 1'b1;
        phase_next = PH_VEX_OP;
      end
      PH_VEX2_B1: begin
        rex_next = {1'b0, ~code_byte[7], 2'b00};
        map_next = 2'd1;
        if (code_byte[1:0] == 2'd1) pfx_next[0] = 1'b1;
        if (code_byte[1:0] == 2'd2) pfx_next[1] = 1'b1;
        if (code_byte[1:0] == 2'd3) pfx_next[2] = 1'b1;
        phase_next = PH_VEX_OP;
      end
      PH_VEX_OP, PH_ESC3: begin
        op_map = map_next;
        opc_next = code_byte;
        if (simd) kind_next[FlSimd] = 1'b1;
        if (need) phase_next = PH_MODRM;
        else done = 1'b1;
      end
      PH_ESC: begin
        if (code_byte == Esc38 || code_byte == Esc3A) begin
          map_next = (code_byte == Esc38) ? 2'd2 : 2'd3;
          phase_next = PH_ESC3;
        end else begin
          op_map = 2'd1;
          map_next = 2'd1;
          opc_next = code_byte;
          if (simd) kind_next[FlSimd] = 1'b1;
          if (need) phase_next = PH_MODRM;
          else done = 1'b1;
        end
      end
      PH_MODRM: begin
        modrm_next = code_byte;
        kind_next[FlModrm] = 1'b1;
        if (code_byte[7:6] == 2'd3) done = 1'b1;
        else if (code_byte[2:0] == 3'd4) phase_next = PH_SIB;
        else if (dok) begin
          rem_next = dsz;
          disp_next = 32'd0;
          phase_next = PH_DISP;
        end else done = 1'b1;
      end
      PH_SIB: begin
        sib_next = code_byte;
        kind_next[FlSib] = 1'b1;
        if (dok) begin
          rem_next = dsz;
          disp_next = 32'd0;
          phase_next = PH_DISP;
        end else done = 1'b1;
      end
      PH_DISP: begin
        disp_next = {code_byte, disp_next[31:8]};
        rem_next = rem_next - 3'd1;
        if (rem_next == 3'd0) begin
          if (modrm_next[7:6] == 2'd1)
            disp_next = {{24{code_byte[7]}}, code_byte};
          kind_next[FlDisp] = 1'b1;
          done = 1'b1;
        end
      end
      default: begin
        phase_next = PH_START;
      end
    endcase
    if (cnt_next >= 4'(MAX_LENGTH)) done = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      cnt <= '0; pfx <= '0; rex <= '0; kind <= '0; map <= '0;
      opc <= '0; modrm <= '0; sib <= '0; disp <= '0; rem <= '0;
      rec_valid <= 1'b0;
    end else begin
      if (acc && done) rec_valid <= 1'b1;
      else if (rec_ready) rec_valid <= 1'b0;
      if (acc) begin
        if (done) begin
          rec.length <= cnt_next;
          rec.opc_map <= map_next;
          rec.opcode_value <= opc_next;
          rec.prefix_flags <= pfx_next;
          rec.rex_bits <= rex_next;
          rec.flags <= kind_next;
          rec.modrm_val <= kind_next[FlModrm] ? modrm_next : 8'd0;
          rec.sib_val <= kind_next[FlSib] ? sib_next : 8'd0;
          rec.displacement <= kind_next[FlDisp] ? disp_next : 32'd0;
          phase <= PH_START;
          cnt <= '0; pfx <= '0; rex <= '0; kind <= '0; map <= '0;
          opc <= '0; modrm <= '0; sib <= '0; disp <= '0; rem <= '0;
        end else begin
          phase <= phase_next; cnt <= cnt_next; pfx <= pfx_next;
          rex <= rex_next; kind <= kind_next; map <= map_next;
          opc <= opc_next; modrm <= modrm_next; sib <= sib_next;
          disp <= disp_next; rem <= rem_next;
        end
      end
    end
  end

  a_len: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> rec.length != 4'd0) else $error("zero length record");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt < 4'(MAX_LENGTH)) else $error("byte count past limit");
  a_disp: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DISP |-> rem != 3'd0) else $error("empty displacement phase");
endmodule
`default_nettype wire

@@ rtl/core/x86ild_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module x86ild_back
  import x86ild_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic rec_valid,
  input  ild_rec_t  rec,
  output logic      rec_ready,
  output logic      out_valid,
  output ild_res_t  res,
  input  wire logic out_ready
);
  assign rec_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_ready) begin
      out_valid <= rec_valid;
      if (rec_valid) begin
        res.length <= rec.length;
        res.opc_map <= rec.opc_map;
        res.opcode_value <= rec.opcode_value;
        res.prefix_flags <= rec.prefix_flags;
        res.rex_bits <= rec.rex_bits;
        res.flags <= rec.flags;
        res.modrm_val <= rec.modrm_val;
        res.sib_val <= rec.sib_val;
        res.displacement <= rec.displacement;
        res.operand_size_code <= rec.prefix_flags[0] ? 2'd0 :
                                 (rec.rex_bits[3] ? 2'd2 : 2'd1);
        res.reg_index <= rec.flags[FlModrm] ?
                         {rec.rex_bits[2], rec.modrm_val[5:3]} : 4'd0;
        res.rm_index <= rec.flags[FlModrm] ?
                        {rec.rex_bits[0], rec.modrm_val[2:0]} : 4'd0;
      end
    end
  end

  a_osz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res.operand_size_code != 2'd3) else $error("bad size code");
  a_reg: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.flags[FlModrm] |-> res.reg_index == 4'd0 && res.rm_index == 4'd0)
    else $error("index without modrm");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result lost");
endmodule
`default_nettype wire

@@ rtl/core/x86_instruction_length_decoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// x86-64 instruction length decoder.
// Channel in (x86ild_in_if sink): one code_byte per transaction, restart=1
// drops any partial decode and makes this byte the first of an instruction.
// Channel out (x86ild_out_if source): one transaction per finished
// instruction: length, map, opcode, prefixes, REX bits, ModRM/SIB,
// sign-extended displacement, operand size and extended reg/rm indexes.
// Throughput: one byte per cycle while in.ready is high, set by the byte parser.
// After an instruction's last byte, the result is registered in the parser
// record register, then in the result register in the back end.
// Instructions end at 15 bytes; a displacement that would pass that is
// not consumed. Immediates are not consumed.
// Reset (rst, synchronous) empties both stages and returns the parser to
// expecting a prefix or opcode. If the receiver stalls, the result holds,
// the record stage fills, and in.ready drops only once both are full.
module x86_instruction_length_decoder_unit
  import x86ild_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MaxLength
) (
  input wire logic   clk,
  input wire logic   rst,
  x86ild_in_if.sink  in,
  x86ild_out_if.source out
);
  logic     rec_valid, rec_ready;
  ild_rec_t rec;

  x86ild_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
    .clk, .rst,
    .in_valid(in.valid), .code_byte(in.code_byte), .restart(in.restart),
    .in_ready(in.ready),
    .rec_valid, .rec, .rec_ready
  );

  x86ild_back u_back (
    .clk, .rst, .rec_valid, .rec, .rec_ready,
    .out_valid(out.valid), .res(out.res), .out_ready(out.ready)
  );
endmodule
`default_nettype wire
